// File: sv/wsp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the WAV stream parser.
// Used by every module of the block; depends on nothing else.
package wsp_pkg;

    localparam int FMT_MAX_BYTES = 256;
    localparam int BC_W          = $clog2(FMT_MAX_BYTES + 1);
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] ID_RIFF = 32'h5249_4646;
    localparam logic [31:0] ID_WAVE = 32'h5741_5645;
    localparam logic [23:0] ID_FMT3 = 24'h46_4D54;
    localparam logic [31:0] ID_DATA = 32'h4441_5441;

    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_HDR  = 3'd1,
        PH_FMT  = 3'd2,
        PH_SKIP = 3'd3,
        PH_DATA = 3'd4,
        PH_IDLE = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_FORMAT = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] raw_sample;
        logic [2:0]  sample_bytes;
        logic [15:0] channels;
        logic [31:0] sample_rate;
        logic [15:0] bits_per_sample;
        logic [31:0] data_bytes;
    } token_t;

    function automatic logic [7:0] upcase(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h61 && b <= 8'h7A) begin
            r = b - 8'h20;
        end
        return r;
    endfunction

endpackage

// File: sv/wsp_front.sv
`timescale 1ns / 1ps
// Front end: accepts file bytes, tracks the RIFF/WAVE parse and assembles raw samples.
// Emits one result token per byte at most. Depends on wsp_pkg.
module wsp_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                byte_valid,
    input  logic [7:0]          byte_data,
    input  logic                byte_sof,
    input  logic                queue_full,
    output logic                byte_ready,
    output logic                tok_push,
    output wsp_pkg::token_t     tok_data
);

    wsp_pkg::phase_t            phase_reg, phase_next;
    logic [wsp_pkg::BC_W-1:0]   bc_reg, bc_next;
    logic [31:0]                cl_reg, cl_next;
    logic [31:0]                id_reg, id_next;
    logic [31:0]                acc_reg, acc_next;
    logic [3:0]                 fbi_reg, fbi_next;
    logic [15:0]                skip_reg, skip_next;
    logic [15:0]                ch_reg, ch_next;
    logic [31:0]                rate_reg, rate_next;
    logic [15:0]                bits_reg, bits_next;
    logic [31:0]                dr_reg, dr_next;
    logic [15:0]                factor_reg, factor_next;

    assign byte_ready = !queue_full;

    always_comb begin
        logic [12:0] bps;
        logic        fmt_ok;
        logic [3:0]  flen;
        logic [16:0] skip_inc;

        phase_next  = phase_reg;
        bc_next     = bc_reg;
        cl_next     = cl_reg;
        id_next     = id_reg;
        acc_next    = acc_reg;
        fbi_next    = fbi_reg;
        skip_next   = skip_reg;
        ch_next     = ch_reg;
        rate_next   = rate_reg;
        bits_next   = bits_reg;
        dr_next     = dr_reg;
        factor_next = factor_reg;
        tok_push    = 1'b0;
        tok_data    = '0;
        bps         = '0;
        fmt_ok      = 1'b0;
        flen        = '0;
        skip_inc    = '0;

        if (cfg_we) begin
            factor_next = (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
        end

        if (byte_valid && byte_ready) begin
            if (byte_sof) begin
                phase_next = wsp_pkg::PH_RIFF;
                bc_next    = '0;
                cl_next    = '0;
                id_next    = '0;
                acc_next   = '0;
                fbi_next   = '0;
                skip_next  = '0;
                ch_next    = '0;
                rate_next  = '0;
                bits_next  = '0;
                dr_next    = '0;
            end

            bps    = bits_next[15:3];
            fmt_ok = (bps >= 13'd1) && (bps <= 13'd4) &&
                     (ch_next == 16'd1 || ch_next == 16'd2);
            flen   = (ch_next == 16'd2) ? {bps[2:0], 1'b0} : {1'b0, bps[2:0]};

            case (phase_next)
                wsp_pkg::PH_RIFF: begin
                    id_next = {id_next[23:0], wsp_pkg::upcase(byte_data)};
                    if ((bc_next == wsp_pkg::BC_W'(3) && id_next != wsp_pkg::ID_RIFF) ||
                        (bc_next == wsp_pkg::BC_W'(11) && id_next != wsp_pkg::ID_WAVE)) begin
                        phase_next    = wsp_pkg::PH_IDLE;
                        tok_push      = 1'b1;
                        tok_data.kind = wsp_pkg::KIND_ERROR;
                    end else if (bc_next == wsp_pkg::BC_W'(11)) begin
                        phase_next = wsp_pkg::PH_HDR;
                        bc_next    = '0;
                    end else begin
                        bc_next = bc_next + 1'b1;
                    end
                end
                wsp_pkg::PH_HDR: begin
                    if (bc_next == '0) begin
                        cl_next = '0;
                    end
                    if (bc_next < wsp_pkg::BC_W'(4)) begin
                        id_next = {id_next[23:0], wsp_pkg::upcase(byte_data)};
                    end else begin
                        cl_next = cl_next | ({24'd0, byte_data} << {bc_next[1:0], 3'b000});
                    end
                    if (bc_next < wsp_pkg::BC_W'(7)) begin
                        bc_next = bc_next + 1'b1;
                    end else begin
                        bc_next = '0;
                        if (id_next[31:8] == wsp_pkg::ID_FMT3) begin
                            if (cl_next > 32'(wsp_pkg::FMT_MAX_BYTES)) begin
                                phase_next    = wsp_pkg::PH_IDLE;
                                tok_push      = 1'b1;
                                tok_data.kind = wsp_pkg::KIND_ERROR;
                            end else begin
                                ch_next    = '0;
                                rate_next  = '0;
                                bits_next  = '0;
                                phase_next = (cl_next == '0) ? wsp_pkg::PH_HDR
                                                             : wsp_pkg::PH_FMT;
                            end
                        end else if (id_next == wsp_pkg::ID_DATA) begin
                            dr_next    = cl_next;
                            fbi_next   = '0;
                            skip_next  = '0;
                            acc_next   = '0;
                            phase_next = (fmt_ok && cl_next != '0) ? wsp_pkg::PH_DATA
                                                                   : wsp_pkg::PH_IDLE;
                            tok_push                 = 1'b1;
                            tok_data.kind            = wsp_pkg::KIND_FORMAT;
                            tok_data.channels        = ch_next;
                            tok_data.sample_rate     = rate_next;
                            tok_data.bits_per_sample = bits_next;
                            tok_data.data_bytes      = cl_next;
                        end else begin
                            phase_next = (cl_next == '0) ? wsp_pkg::PH_HDR
                                                         : wsp_pkg::PH_SKIP;
                        end
                    end
                end
                wsp_pkg::PH_FMT: begin
                    if (bc_next == wsp_pkg::BC_W'(2)) begin
                        ch_next[7:0] = ch_next[7:0] | byte_data;
                    end else if (bc_next == wsp_pkg::BC_W'(3)) begin
                        ch_next[15:8] = ch_next[15:8] | byte_data;
                    end else if (bc_next >= wsp_pkg::BC_W'(4) &&
                                 bc_next <= wsp_pkg::BC_W'(7)) begin
                        rate_next = rate_next |
                                    ({24'd0, byte_data} << {bc_next[1:0], 3'b000});
                    end else if (bc_next == wsp_pkg::BC_W'(14)) begin
                        bits_next[7:0] = bits_next[7:0] | byte_data;
                    end else if (bc_next == wsp_pkg::BC_W'(15)) begin
                        bits_next[15:8] = bits_next[15:8] | byte_data;
                    end
                    bc_next = bc_next + 1'b1;
                    if (32'(bc_next) >= cl_next) begin
                        phase_next = wsp_pkg::PH_HDR;
                        bc_next    = '0;
                    end
                end
                wsp_pkg::PH_SKIP: begin
                    cl_next = cl_next - 32'd1;
                    if (cl_next == '0) begin
                        phase_next = wsp_pkg::PH_HDR;
                        bc_next    = '0;
                    end
                end
                wsp_pkg::PH_DATA: begin
                    if (!fmt_ok) begin
                        phase_next = wsp_pkg::PH_IDLE;
                    end else begin
                        if (13'(fbi_next) < bps) begin
                            acc_next = acc_next |
                                       ({24'd0, byte_data} << {fbi_next[1:0], 3'b000});
                        end
                        fbi_next = fbi_next + 4'd1;
                        dr_next  = dr_next - 32'd1;
                        if (fbi_next >= flen) begin
                            if (skip_next == '0) begin
                                tok_push              = 1'b1;
                                tok_data.kind         = wsp_pkg::KIND_SAMPLE;
                                tok_data.raw_sample   = acc_next;
                                tok_data.sample_bytes = bps[2:0];
                            end
                            skip_inc  = {1'b0, skip_next} + 17'd1;
                            skip_next = (skip_inc >= {1'b0, factor_reg}) ? 16'd0
                                                                         : skip_inc[15:0];
                            fbi_next  = '0;
                            acc_next  = '0;
                        end
                        if (dr_next == '0) begin
                            phase_next = wsp_pkg::PH_IDLE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= wsp_pkg::PH_RIFF;
            bc_reg     <= '0;
            cl_reg     <= '0;
            id_reg     <= '0;
            acc_reg    <= '0;
            fbi_reg    <= '0;
            skip_reg   <= '0;
            ch_reg     <= '0;
            rate_reg   <= '0;
            bits_reg   <= '0;
            dr_reg     <= '0;
            factor_reg <= 16'd1;
        end else begin
            phase_reg  <= phase_next;
            bc_reg     <= bc_next;
            cl_reg     <= cl_next;
            id_reg     <= id_next;
            acc_reg    <= acc_next;
            fbi_reg    <= fbi_next;
            skip_reg   <= skip_next;
            ch_reg     <= ch_next;
            rate_reg   <= rate_next;
            bits_reg   <= bits_next;
            dr_reg     <= dr_next;
            factor_reg <= factor_next;
        end
    end

endmodule

// File: sv/wsp_queue.sv
`timescale 1ns / 1ps
// Short token queue between the parser front end and the output back end.
// Depends on wsp_pkg for the token type and depth.
module wsp_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  wsp_pkg::token_t  push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output wsp_pkg::token_t  head
);

    wsp_pkg::token_t                entry_reg [wsp_pkg::QUEUE_DEPTH];
    logic [wsp_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [wsp_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [wsp_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign full      = (count_reg == wsp_pkg::QCNT_W'(wsp_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/wsp_back.sv
`timescale 1ns / 1ps
// Back end: takes tokens from the queue, sign-extends samples and holds the result beat.
// Depends on wsp_pkg.
module wsp_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             tok_valid,
    input  wsp_pkg::token_t  tok,
    output logic             tok_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_kind,
    output logic [31:0]      m_sample,
    output logic [15:0]      m_channels,
    output logic [31:0]      m_sample_rate,
    output logic [15:0]      m_bits_per_sample,
    output logic [31:0]      m_data_bytes
);

    logic             valid_reg, valid_next;
    wsp_pkg::kind_t   kind_reg;
    logic [31:0]      sample_reg, sample_next;
    logic [15:0]      ch_reg;
    logic [31:0]      rate_reg;
    logic [15:0]      bits_reg;
    logic [31:0]      len_reg;

    assign tok_pop = tok_valid && (!valid_reg || m_ready);

    always_comb begin
        valid_next = tok_pop ? 1'b1 : (valid_reg && !m_ready);
        case (tok.sample_bytes)
            3'd1:    sample_next = {{24{tok.raw_sample[7]}}, tok.raw_sample[7:0]};
            3'd2:    sample_next = {{16{tok.raw_sample[15]}}, tok.raw_sample[15:0]};
            3'd3:    sample_next = {{8{tok.raw_sample[23]}}, tok.raw_sample[23:0]};
            default: sample_next = tok.raw_sample;
        endcase
        if (tok.kind != wsp_pkg::KIND_SAMPLE) begin
            sample_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_pop) begin
            kind_reg   <= tok.kind;
            sample_reg <= sample_next;
            ch_reg     <= tok.channels;
            rate_reg   <= tok.sample_rate;
            bits_reg   <= tok.bits_per_sample;
            len_reg    <= tok.data_bytes;
        end
    end

    assign m_valid           = valid_reg;
    assign m_kind            = kind_reg;
    assign m_sample          = sample_reg;
    assign m_channels        = ch_reg;
    assign m_sample_rate     = rate_reg;
    assign m_bits_per_sample = bits_reg;
    assign m_data_bytes      = len_reg;

endmodule

// File: sv/wav_stream_parse_decimate_top.sv
`timescale 1ns / 1ps
// Top level of the byte-serial WAV parser with first-channel frame decimation.
// Instantiates wsp_front, wsp_queue and wsp_back; depends on wsp_pkg.
//
//   Channel   Direction   Handshake           Payload
//   s_        in          s_valid / s_ready   s_data_byte, s_start_of_file
//   m_        out         m_valid / m_ready   m_kind, m_sample, m_channels, m_sample_rate,
//                                             m_bits_per_sample, m_data_bytes
//   cfg_      in          cfg_we              cfg_wdata (decimation factor)
//
// One input beat is taken per cycle unless s_ready is low; the parser updates all of its state
// in that cycle. A result passes through the token queue and then the output register before
// it reaches m_. Reset is synchronous on aresetn and returns the parser to the RIFF header
// with a decimation factor of one. s_ready drops only while the four-entry queue is full.
module wav_stream_parse_decimate_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_data_byte,
    input  logic         s_start_of_file,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [1:0]   m_kind,
    output logic [31:0]  m_sample,
    output logic [15:0]  m_channels,
    output logic [31:0]  m_sample_rate,
    output logic [15:0]  m_bits_per_sample,
    output logic [31:0]  m_data_bytes
);

    logic             q_full;
    logic             q_not_empty;
    logic             q_push;
    logic             q_pop;
    wsp_pkg::token_t  q_in;
    wsp_pkg::token_t  q_head;

    wsp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .byte_valid (s_valid),
        .byte_data  (s_data_byte),
        .byte_sof   (s_start_of_file),
        .queue_full (q_full),
        .byte_ready (s_ready),
        .tok_push   (q_push),
        .tok_data   (q_in)
    );

    wsp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    wsp_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .tok_valid         (q_not_empty),
        .tok               (q_head),
        .tok_pop           (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_sample          (m_sample),
        .m_channels        (m_channels),
        .m_sample_rate     (m_sample_rate),
        .m_bits_per_sample (m_bits_per_sample),
        .m_data_bytes      (m_data_bytes)
    );

endmodule

// File: sv/wsp_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the WAV parser top level, attached with a bind statement.
// Depends on wsp_pkg and wav_stream_parse_decimate_top.
module wsp_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         m_valid,
    input  logic         m_ready,
    input  logic [1:0]   m_kind,
    input  logic [31:0]  m_sample,
    input  logic [15:0]  m_channels,
    input  logic [31:0]  m_sample_rate,
    input  logic [15:0]  m_bits_per_sample,
    input  logic [31:0]  m_data_bytes
);

    // A stalled result beat keeps its kind and sample.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_sample))
        else $error("result beat changed while stalled");

    a_no_valid_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind == wsp_pkg::KIND_SAMPLE || m_kind == wsp_pkg::KIND_FORMAT ||
                     m_kind == wsp_pkg::KIND_ERROR))
        else $error("unused result kind");

    a_sample_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != wsp_pkg::KIND_SAMPLE |-> m_sample == 32'd0)
        else $error("sample not zero on a non-sample beat");

    a_format_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != wsp_pkg::KIND_FORMAT |->
            m_channels == 16'd0 && m_sample_rate == 32'd0 &&
            m_bits_per_sample == 16'd0 && m_data_bytes == 32'd0)
        else $error("format fields not zero on a non-format beat");

endmodule

bind wav_stream_parse_decimate_top wsp_checker u_wsp_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_kind            (m_kind),
    .m_sample          (m_sample),
    .m_channels        (m_channels),
    .m_sample_rate     (m_sample_rate),
    .m_bits_per_sample (m_bits_per_sample),
    .m_data_bytes      (m_data_bytes)
);

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for wav_stream_parse_decimate_top, with a built-in parser model.
// Runs directed header cases, then random WAV files under several decimation factors and stalls.
// Depends on wsp_pkg and the RTL of the block.
module testbench;

    localparam int RANDOM_BEATS = 1225;
    localparam int PHASE_BEATS  = 200;
    localparam int TAIL_BEATS   = 150;
    localparam int SETTLE       = 8;
    localparam int LONG_HOLD    = 500;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DIR_ROWS     = 25;

    typedef struct packed {
        wsp_pkg::kind_t kind;
        logic [31:0]    sample;
        logic [15:0]    channels;
        logic [31:0]    rate;
        logic [15:0]    bits;
        logic [31:0]    length;
    } wav_result_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        sof;
        logic        pinned;
        wav_result_t want;
    } dir_row_t;

    localparam wav_result_t NO_RESULT = '0;
    localparam wav_result_t HDR_ERROR = {wsp_pkg::KIND_ERROR, 128'd0};

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_start_of_file;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_kind;
    logic [31:0] m_sample;
    logic [15:0] m_channels;
    logic [31:0] m_sample_rate;
    logic [15:0] m_bits_per_sample;
    logic [31:0] m_data_bytes;

    wav_stream_parse_decimate_top dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_start_of_file   (s_start_of_file),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_sample          (m_sample),
        .m_channels        (m_channels),
        .m_sample_rate     (m_sample_rate),
        .m_bits_per_sample (m_bits_per_sample),
        .m_data_bytes      (m_data_bytes)
    );

    wav_result_t expected_results[$];
    logic [7:0]  file_q[$];
    dir_row_t    directed_rows [0:DIR_ROWS-1];

    int unsigned cycle_count = 0;
    int          failures = 0;
    int          results_seen = 0;
    int          beats_sent = 0;
    int          files_sent = 0;
    int          settings_used = 0;
    bit          tail_part = 0;

    wsp_pkg::phase_t parse_phase;
    logic [31:0] hdr_count;
    logic [31:0] chunk_len;
    logic [31:0] id_word;
    logic [31:0] sample_acc;
    logic [31:0] frame_pos;
    logic [31:0] skip_count;
    logic [15:0] fmt_channels;
    logic [31:0] fmt_rate;
    logic [15:0] fmt_bits;
    logic [31:0] data_left;
    logic [15:0] keep_every;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    function automatic logic [7:0] to_upper(input logic [7:0] b);
        if (b >= "a" && b <= "z") begin
            return b - 8'h20;
        end
        return b;
    endfunction

    function automatic bit format_usable();
        int unsigned bps;
        bps = fmt_bits / 8;
        return bps >= 1 && bps <= 4 && (fmt_channels == 16'd1 || fmt_channels == 16'd2);
    endfunction

    task automatic add_byte(input logic [7:0] b);
        file_q = {file_q, b};
    endtask

    task automatic add_expected(input wav_result_t r);
        expected_results = {expected_results, r};
    endtask

    task automatic restart_parse();
        parse_phase  = wsp_pkg::PH_RIFF;
        hdr_count    = '0;
        chunk_len    = '0;
        id_word      = '0;
        sample_acc   = '0;
        frame_pos    = '0;
        skip_count   = '0;
        fmt_channels = '0;
        fmt_rate     = '0;
        fmt_bits     = '0;
        data_left    = '0;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic sof,
                                output bit got, output wav_result_t res);
        int unsigned bps;
        int unsigned flen;
        logic [31:0] v;
        logic [31:0] m;
        got = 0;
        res = NO_RESULT;
        if (sof) begin
            restart_parse();
        end
        case (parse_phase)
            wsp_pkg::PH_RIFF: begin
                id_word = {id_word[23:0], to_upper(b)};
                if ((hdr_count == 3 && id_word != wsp_pkg::ID_RIFF) ||
                    (hdr_count == 11 && id_word != wsp_pkg::ID_WAVE)) begin
                    parse_phase = wsp_pkg::PH_IDLE;
                    got = 1;
                    res.kind = wsp_pkg::KIND_ERROR;
                end else if (hdr_count == 11) begin
                    parse_phase = wsp_pkg::PH_HDR;
                    hdr_count = '0;
                end else begin
                    hdr_count++;
                end
            end
            wsp_pkg::PH_HDR: begin
                if (hdr_count == 0) begin
                    chunk_len = '0;
                end
                if (hdr_count < 4) begin
                    id_word = {id_word[23:0], to_upper(b)};
                end else begin
                    chunk_len |= {24'd0, b} << (8 * ((hdr_count - 4) & 3));
                end
                if (hdr_count < 7) begin
                    hdr_count++;
                end else begin
                    hdr_count = '0;
                    if (id_word[31:8] == wsp_pkg::ID_FMT3) begin
                        if (chunk_len > $unsigned(wsp_pkg::FMT_MAX_BYTES)) begin
                            parse_phase = wsp_pkg::PH_IDLE;
                            got = 1;
                            res.kind = wsp_pkg::KIND_ERROR;
                        end else begin
                            fmt_channels = '0;
                            fmt_rate = '0;
                            fmt_bits = '0;
                            parse_phase = (chunk_len == 0) ? wsp_pkg::PH_HDR
                                                           : wsp_pkg::PH_FMT;
                        end
                    end else if (id_word == wsp_pkg::ID_DATA) begin
                        data_left = chunk_len;
                        frame_pos = '0;
                        skip_count = '0;
                        sample_acc = '0;
                        parse_phase = (format_usable() && chunk_len != 0) ? wsp_pkg::PH_DATA
                                                                          : wsp_pkg::PH_IDLE;
                        got = 1;
                        res.kind = wsp_pkg::KIND_FORMAT;
                        res.channels = fmt_channels;
                        res.rate = fmt_rate;
                        res.bits = fmt_bits;
                        res.length = chunk_len;
                    end else begin
                        parse_phase = (chunk_len == 0) ? wsp_pkg::PH_HDR : wsp_pkg::PH_SKIP;
                    end
                end
            end
            wsp_pkg::PH_FMT: begin
                case (hdr_count)
                    2: fmt_channels[7:0] |= b;
                    3: fmt_channels[15:8] |= b;
                    4, 5, 6, 7: fmt_rate |= {24'd0, b} << (8 * (hdr_count - 4));
                    14: fmt_bits[7:0] |= b;
                    15: fmt_bits[15:8] |= b;
                    default: ;
                endcase
                hdr_count++;
                if (hdr_count >= chunk_len) begin
                    parse_phase = wsp_pkg::PH_HDR;
                    hdr_count = '0;
                end
            end
            wsp_pkg::PH_SKIP: begin
                chunk_len--;
                if (chunk_len == 0) begin
                    parse_phase = wsp_pkg::PH_HDR;
                    hdr_count = '0;
                end
            end
            wsp_pkg::PH_DATA: begin
                if (!format_usable()) begin
                    parse_phase = wsp_pkg::PH_IDLE;
                end else begin
                    bps = fmt_bits / 8;
                    flen = bps * fmt_channels;
                    if (frame_pos < bps) begin
                        sample_acc |= {24'd0, b} << (8 * (frame_pos & 3));
                    end
                    frame_pos++;
                    data_left--;
                    if (frame_pos >= flen) begin
                        if (skip_count == 0) begin
                            v = sample_acc;
                            if (bps < 4) begin
                                m = 32'd1 << (8 * bps - 1);
                                v = ((v & ((32'd1 << (8 * bps)) - 1)) ^ m) - m;
                            end
                            got = 1;
                            res.kind = wsp_pkg::KIND_SAMPLE;
                            res.sample = v;
                        end
                        skip_count = (skip_count + 1 >= {16'd0, keep_every}) ? 32'd0
                                                                           : skip_count + 1;
                        frame_pos = '0;
                        sample_acc = '0;
                    end
                    if (data_left == 0) begin
                        parse_phase = wsp_pkg::PH_IDLE;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic set_factor(input logic [15:0] v);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        keep_every = (v == 16'd0) ? 16'd1 : v;
        settings_used++;
    endtask

    function automatic logic [15:0] factor_for(input int idx);
        case (idx)
            0: return 16'd1;
            1: return 16'd2;
            2: return 16'd65535;
            3: return 16'd3;
            4: return 16'd0;
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic sof, input logic pinned,
                             input wav_result_t want);
        bit          got;
        wav_result_t res;
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_start_of_file <= sof;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_byte(b, sof, got, res);
        if (pinned) begin
            add_expected(want);
        end else if (got) begin
            add_expected(res);
        end
        beats_sent++;
    endtask

    task automatic idle_gap();
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [7:0] any_case(input logic [7:0] b);
        if (b >= "A" && b <= "Z" && $urandom_range(0, 1) == 1) begin
            return b | 8'h20;
        end
        return b;
    endfunction

    task automatic emit_id(input logic [31:0] id);
        for (int i = 3; i >= 0; i--) begin
            add_byte(any_case(id[8*i +: 8]));
        end
    endtask

    task automatic emit_le32(input logic [31:0] v);
        for (int i = 0; i < 4; i++) begin
            add_byte(v[8*i +: 8]);
        end
    endtask

    task automatic emit_junk_chunk();
        int n;
        for (int i = 0; i < 4; i++) begin
            add_byte(any_case(8'(8'h41 + $urandom_range(0, 25))));
        end
        n = $urandom_range(0, 6);
        emit_le32(n);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic emit_pcm_byte();
        case ($urandom_range(0, 7))
            0: add_byte(8'h00);
            1: add_byte(8'h7F);
            2: add_byte(8'h80);
            3: add_byte(8'hFF);
            default: add_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic build_file();
        int          pick;
        int          r;
        int          fmt_len;
        int          ch;
        int          bits;
        int          flen;
        int          n;
        bit          usable;
        bit          truncated;
        logic [31:0] rate;
        logic [31:0] data_len;
        file_q.delete();
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            n = $urandom_range(1, 30);
            repeat (n) add_byte(8'($urandom_range(0, 255)));
            return;
        end
        emit_id(wsp_pkg::ID_RIFF);
        emit_le32($urandom);
        emit_id(wsp_pkg::ID_WAVE);
        if ($urandom_range(0, 3) == 0) begin
            emit_junk_chunk();
        end
        r = $urandom_range(0, 99);
        if (r < 70) fmt_len = 16;
        else if (r < 80) fmt_len = 18;
        else if (r < 88) fmt_len = $urandom_range(0, 15);
        else if (r < 95) fmt_len = $urandom_range(17, 40);
        else fmt_len = $urandom_range(wsp_pkg::FMT_MAX_BYTES + 1, wsp_pkg::FMT_MAX_BYTES + 44);
        ch = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 2) : $urandom_range(0, 3);
        r = $urandom_range(0, 99);
        if (r < 85) bits = 8 * $urandom_range(1, 4);
        else if (r < 93) bits = $urandom_range(0, 65535);
        else bits = 8 * $urandom_range(5, 8);
        rate = $urandom;
        emit_id({wsp_pkg::ID_FMT3,
                 ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h20});
        emit_le32(fmt_len);
        if (fmt_len > wsp_pkg::FMT_MAX_BYTES) begin
            repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
            return;
        end
        for (int off = 0; off < fmt_len; off++) begin
            case (off)
                0: add_byte(8'h01);
                1: add_byte(8'h00);
                2: add_byte(ch[7:0]);
                3: add_byte(ch[15:8]);
                4, 5, 6, 7: add_byte(rate[8*(off-4) +: 8]);
                14: add_byte(bits[7:0]);
                15: add_byte(bits[15:8]);
                default: add_byte(8'($urandom_range(0, 255)));
            endcase
        end
        if ($urandom_range(0, 3) == 0) begin
            emit_junk_chunk();
        end
        emit_id(wsp_pkg::ID_DATA);
        usable = fmt_len >= 16 && bits / 8 >= 1 && bits / 8 <= 4 && (ch == 1 || ch == 2);
        flen = usable ? (bits / 8) * ch : 1;
        truncated = 0;
        r = $urandom_range(0, 99);
        if (!usable) begin
            data_len = $urandom_range(0, 6);
        end else if (r < 10) begin
            data_len = $urandom | 32'h0100_0000;
            truncated = 1;
        end else begin
            data_len = $urandom_range(0, 8) * flen;
            if (r < 25) begin
                data_len += $urandom_range(0, flen - 1);
            end
        end
        emit_le32(data_len);
        n = truncated ? $urandom_range(0, 24) : data_len;
        repeat (n) emit_pcm_byte();
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
        end
        if (pick < 16) begin
            n = $urandom_range(0, 7);
            file_q[(n < 4) ? n : n + 4] = 8'($urandom_range(0, 255));
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            failures++;
        end
    endtask

    task automatic check_result();
        wav_result_t want;
        results_seen++;
        if (expected_results.size() == 0) begin
            $error("result beat with nothing expected: kind %0d", m_kind);
            failures++;
        end else begin
            want = expected_results.pop_front();
            check_field("kind", want.kind, m_kind);
            check_field("sample", want.sample, m_sample);
            check_field("channels", want.channels, m_channels);
            check_field("sample_rate", want.rate, m_sample_rate);
            check_field("bits_per_sample", want.bits, m_bits_per_sample);
            check_field("data_bytes", want.length, m_data_bytes);
        end
    endtask

    initial begin
        int  hold;
        bit  long_done;
        hold = 0;
        long_done = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_result();
            end
            if (!long_done && results_seen >= 40) begin
                hold = LONG_HOLD;
                long_done = 1;
            end else if (hold == 0 && !tail_part && (cycle_count / 300) % 3 != 2 &&
                         $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 17);
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int rand_beats;
        int phase_beats;
        int phase_idx;
        s_valid <= 1'b0;
        s_data_byte <= 8'h00;
        s_start_of_file <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= 16'h0000;
        aresetn <= 1'b0;
        keep_every = 16'd1;
        restart_parse();
        directed_rows = '{
            {"R", 1'b1, 1'b0, NO_RESULT},
            {"I", 1'b0, 1'b0, NO_RESULT},
            {"F", 1'b0, 1'b0, NO_RESULT},
            {"X", 1'b0, 1'b1, HDR_ERROR},
            {"r", 1'b1, 1'b0, NO_RESULT},
            {"i", 1'b0, 1'b0, NO_RESULT},
            {"f", 1'b0, 1'b0, NO_RESULT},
            {"f", 1'b0, 1'b0, NO_RESULT},
            {8'hFF, 1'b0, 1'b0, NO_RESULT},
            {8'hFF, 1'b0, 1'b0, NO_RESULT},
            {8'hFF, 1'b0, 1'b0, NO_RESULT},
            {8'hFF, 1'b0, 1'b0, NO_RESULT},
            {"w", 1'b0, 1'b0, NO_RESULT},
            {"a", 1'b0, 1'b0, NO_RESULT},
            {"v", 1'b0, 1'b0, NO_RESULT},
            {"e", 1'b0, 1'b0, NO_RESULT},
            {"F", 1'b0, 1'b0, NO_RESULT},
            {"M", 1'b0, 1'b0, NO_RESULT},
            {"T", 1'b0, 1'b0, NO_RESULT},
            {" ", 1'b0, 1'b0, NO_RESULT},
            {8'h2C, 1'b0, 1'b0, NO_RESULT},
            {8'h01, 1'b0, 1'b0, NO_RESULT},
            {8'h00, 1'b0, 1'b0, NO_RESULT},
            {8'h00, 1'b0, 1'b1, HDR_ERROR},
            {"R", 1'b0, 1'b0, NO_RESULT}
        };
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                idle_gap();
            end
            send_beat(directed_rows[i].data, directed_rows[i].sof,
                      directed_rows[i].pinned, directed_rows[i].want);
        end
        drain();

        rand_beats = 0;
        phase_beats = 0;
        phase_idx = 0;
        set_factor(factor_for(phase_idx));
        while (rand_beats < RANDOM_BEATS) begin
            build_file();
            files_sent++;
            for (int k = 0; k < file_q.size() && rand_beats < RANDOM_BEATS; k++) begin
                if (phase_beats >= PHASE_BEATS) begin
                    drain();
                    phase_idx++;
                    set_factor(factor_for(phase_idx));
                    phase_beats = 0;
                end
                tail_part = rand_beats >= RANDOM_BEATS - TAIL_BEATS;
                if (!tail_part && (rand_beats / 100) % 3 != 2 && $urandom_range(0, 7) == 0) begin
                    idle_gap();
                end
                send_beat(file_q[k], k == 0, 1'b0, NO_RESULT);
                rand_beats++;
                phase_beats++;
            end
        end
        drain();

        $display("Sent %0d input beats (%0d random files) under %0d decimation settings.",
                 beats_sent, files_sent, settings_used);
        $display("Checked %0d result beats, including a %0d-cycle output stall.",
                 results_seen, LONG_HOLD);
        if (failures == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
